@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/blpg_pkg.sv @@
// ----------------------------------------------------------------------------
// blpg_pkg
// Widths, codes and shared types of the line pixel generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

  localparam int COORD_BITS     = 11;
  localparam int ADDR_BITS      = 23;
  localparam int ERR_BITS       = COORD_BITS + 2;
  localparam int DIM_BITS       = 12;
  localparam int COLOR_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(600);

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ROTATE_MODE  = 2'd2
  } reg_index_t;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic                  is_start;
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    coord_t                span_x;
    coord_t                span_y;
    logic                  neg_x;
    logic                  neg_y;
    err_t                  err;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic                rotate_mode;
  } frame_cfg_t;

  typedef struct packed {
    logic [QUEUE_CNT_BITS-1:0] count;
    logic                      full;
  } queue_stat_t;

  typedef struct packed {
    logic active;
    logic load_last;
  } back_stat_t;

endpackage

@@ rtl/core/blpg_if.sv @@
// ----------------------------------------------------------------------------
// blpg_if
// Valid/ready channels of the line pixel generator.
// ----------------------------------------------------------------------------
interface blpg_cmd_if import blpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  action_t               action;
  coord_t                start_x;
  coord_t                start_y;
  coord_t                end_x;
  coord_t                end_y;
  logic [COLOR_BITS-1:0] pen_color;

  modport source (output valid, action, start_x, start_y, end_x, end_y, pen_color,
                  input ready);
  modport sink (input valid, action, start_x, start_y, end_x, end_y, pen_color,
                output ready);
endinterface

interface blpg_pix_if import blpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  coord_t                pixel_x;
  coord_t                pixel_y;
  logic [ADDR_BITS-1:0]  pixel_address;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last,
                output ready);
endinterface

interface blpg_cfg_if import blpg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/blpg_front.sv @@
// ----------------------------------------------------------------------------
// blpg_front
// Accept commands, classify them and precompute the line setup terms.
// ----------------------------------------------------------------------------
module blpg_front import blpg_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  blpg_cmd_if.sink       cmd,
  output logic           push_valid,
  input  logic           push_ready,
  output cmd_t           push_cmd
);

  logic   valid;
  cmd_t   held;
  cmd_t   setup;
  coord_t dx;
  coord_t dy;

  assign cmd.ready = !valid || push_ready;

  // Spans, step signs and starting error term of a new line.
  always_comb begin
    dx = (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x : cmd.start_x - cmd.end_x;
    dy = (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y : cmd.start_y - cmd.end_y;
    setup.is_start = (cmd.action == ACT_START);
    setup.x0       = cmd.start_x;
    setup.y0       = cmd.start_y;
    setup.x1       = cmd.end_x;
    setup.y1       = cmd.end_y;
    setup.span_x   = dx;
    setup.span_y   = dy;
    setup.neg_x    = !(cmd.start_x < cmd.end_x);
    setup.neg_y    = !(cmd.start_y < cmd.end_y);
    setup.err      = (dx > dy) ? err_t'(ERR_BITS'(dx >> 1))
                               : -err_t'(ERR_BITS'(dy >> 1));
    setup.color    = cmd.pen_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      held <= setup;
    end
  end

  assign push_valid = valid;
  assign push_cmd   = held;

endmodule

@@ rtl/core/blpg_queue.sv @@
// ----------------------------------------------------------------------------
// blpg_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module blpg_queue import blpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cmd_t        out_data,
  output queue_stat_t stat
);

  cmd_t                      slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      push;
  logic                      pop;

  function automatic logic [QUEUE_PTR_BITS-1:0] bump(input logic [QUEUE_PTR_BITS-1:0] p);
    return (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_BITS'(1);
  endfunction

  assign in_ready  = (count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  assign stat.count = count;
  assign stat.full  = !in_ready;

endmodule

@@ rtl/core/blpg_back.sv @@
// ----------------------------------------------------------------------------
// blpg_back
// Step the line, map each pixel to its frame-buffer address, drive results.
// ----------------------------------------------------------------------------
module blpg_back import blpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  frame_cfg_t fcfg,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd_data,
  blpg_pix_if.source pix,
  output back_stat_t stat
);

  // line state
  coord_t                cur_x, cur_y, tgt_x, tgt_y, span_x, span_y;
  logic                  neg_x, neg_y;
  err_t                  err;
  logic [COLOR_BITS-1:0] color;
  logic                  active;

  // step results
  coord_t cur_x_next, cur_y_next;
  err_t   err_next;
  logic   emit, last_next, take;
  err_t   sx, sy;
  logic   step_x, step_y;

  // stage A: stepped pixel
  logic                  a_valid;
  coord_t                a_x, a_y;
  logic [COLOR_BITS-1:0] a_color;
  logic                  a_last;

  // stage B: product and offset
  logic                  b_valid;
  coord_t                b_x, b_y;
  logic [COLOR_BITS-1:0] b_color;
  logic                  b_last;
  logic [ADDR_BITS-1:0]  b_prod, b_offs;
  logic [ADDR_BITS-1:0]  mul_w, mul_m, offs;

  logic a_en, b_en, o_en;

  assign o_en      = !pix.valid || pix.ready;
  assign b_en      = !b_valid || o_en;
  assign a_en      = !a_valid || b_en;
  assign cmd_ready = a_en;
  assign take      = cmd_valid && a_en;

  always_comb begin
    sx     = err_t'(ERR_BITS'(span_x));
    sy     = err_t'(ERR_BITS'(span_y));
    step_x = err > -sx;
    step_y = err < sy;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    err_next   = err - (step_x ? sy : err_t'(0)) + (step_y ? sx : err_t'(0));
    if (step_x) begin
      cur_x_next = neg_x ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
    end
    if (step_y) begin
      cur_y_next = neg_y ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
    end
    priority if (cmd_data.is_start) begin
      emit      = 1'b1;
      last_next = (cmd_data.x0 == cmd_data.x1) && (cmd_data.y0 == cmd_data.y1);
    end else if (active) begin
      emit      = 1'b1;
      last_next = (cur_x_next == tgt_x) && (cur_y_next == tgt_y);
    end else begin
      emit      = 1'b0;
      last_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x  <= '0;
      cur_y  <= '0;
      tgt_x  <= '0;
      tgt_y  <= '0;
      span_x <= '0;
      span_y <= '0;
      neg_x  <= 1'b0;
      neg_y  <= 1'b0;
      err    <= '0;
      color  <= '0;
      active <= 1'b0;
    end else if (take) begin
      if (cmd_data.is_start) begin
        cur_x  <= cmd_data.x0;
        cur_y  <= cmd_data.y0;
        tgt_x  <= cmd_data.x1;
        tgt_y  <= cmd_data.y1;
        span_x <= cmd_data.span_x;
        span_y <= cmd_data.span_y;
        neg_x  <= cmd_data.neg_x;
        neg_y  <= cmd_data.neg_y;
        err    <= cmd_data.err;
        color  <= cmd_data.color;
        active <= !last_next;
      end else if (active) begin
        cur_x  <= cur_x_next;
        cur_y  <= cur_y_next;
        err    <= err_next;
        active <= !last_next;
      end
    end
  end

  // stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_x     <= cmd_data.is_start ? cmd_data.x0 : cur_x_next;
      a_y     <= cmd_data.is_start ? cmd_data.y0 : cur_y_next;
      a_color <= cmd_data.is_start ? cmd_data.color : color;
      a_last  <= last_next;
    end
  end

  // stage B: width times row, plus column term
  always_comb begin
    mul_w = ADDR_BITS'(fcfg.frame_width);
    if (fcfg.rotate_mode) begin
      mul_m = ADDR_BITS'(fcfg.frame_height) - ADDR_BITS'(a_y);
      offs  = ADDR_BITS'(fcfg.frame_width) - ADDR_BITS'(a_x);
    end else begin
      mul_m = ADDR_BITS'(a_y);
      offs  = ADDR_BITS'(a_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && a_valid) begin
      b_x     <= a_x;
      b_y     <= a_y;
      b_color <= a_color;
      b_last  <= a_last;
      b_prod  <= mul_w * mul_m;
      b_offs  <= offs;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (o_en) begin
      pix.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en && b_valid) begin
      pix.pixel_x       <= b_x;
      pix.pixel_y       <= b_y;
      pix.pixel_color   <= b_color;
      pix.last          <= b_last;
      pix.pixel_address <= b_prod + b_offs;
    end
  end

  assign stat.active    = active;
  assign stat.load_last = take && emit && last_next;

endmodule

@@ rtl/core/bresenham_line_pixel_generator_core.sv @@
// Start and advance pixels pass front, queue, stage A, stage B and output registers.
// Throughput: one item, one pixel per clock, set by the step loop, unless stalled.
// An advance with no line in progress is consumed and gives no pixel.
// Reset (rst, synchronous): no line active, queue empty, output empty,
// frame width 800, frame height 600, normal address mapping.
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_core
// Line rasterizer: front classifies and sets up lines, a short queue decouples
// it from the back, which steps the line and computes frame-buffer addresses.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bresenham_line_pixel_generator_core import blpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  blpg_cmd_if.sink   cmd,
  blpg_pix_if.source pix,
  blpg_cfg_if.sink   cfg
);

  // Frame configuration registers: user writes only while the engine is idle (unchecked).
  frame_cfg_t fcfg;

  // Front to queue transfer.
  logic        f_valid;
  logic        f_ready;
  cmd_t        f_cmd;

  // Queue to back transfer.
  logic        q_valid;
  logic        q_ready;
  cmd_t        q_cmd;

  queue_stat_t q_stat;
  back_stat_t  b_stat;

  // Always take configuration writes; drop writes to unknown indexes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcfg.frame_width  <= FRAME_WIDTH_RESET;
      fcfg.frame_height <= FRAME_HEIGHT_RESET;
      fcfg.rotate_mode  <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  fcfg.frame_width  <= DIM_BITS'(cfg.data);
        REG_FRAME_HEIGHT: fcfg.frame_height <= DIM_BITS'(cfg.data);
        REG_ROTATE_MODE:  fcfg.rotate_mode  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Front: accept the command and precompute spans, signs and error term.
  blpg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd)
  );

  // Queue: absorb stalls so the front keeps taking commands.
  blpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_cmd),
    .stat      (q_stat)
  );

  // Back: step the line state and drive pixels through the address pipe.
  blpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fcfg      (fcfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .pix       (pix),
    .stat      (b_stat)
  );

  // Queue occupancy never exceeds its depth.
  `ASSERT_SAME(a_queue_bound, clk, rst, 1'b1, q_stat.count <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue overflow")

  // A full queue must hold the front back.
  `ASSERT_SAME(a_full_stalls, clk, rst, q_stat.full, !f_ready, "push into full queue")

  // Loading a line's endpoint ends the line.
  `ASSERT_NEXT(a_last_ends_line, clk, rst, b_stat.load_last, !b_stat.active, "line active after endpoint")

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line pixel generator. Drives start and advance
// commands, programs the frame registers between phases, and checks every
// pixel transfer against an in-bench Bresenham predictor.
// ----------------------------------------------------------------------------
module tb import blpg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  // Pixels trail their command through the engine's registers; give ample margin.
  localparam int DRAIN_CYCLES = 12;
  // Index 3 is unmapped; a write there must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct {
    coord_t                x;
    coord_t                y;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;

  blpg_cmd_if cmd_if ();
  blpg_pix_if pix_if ();
  blpg_cfg_if cfg_if ();

  bresenham_line_pixel_generator_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .pix (pix_if),
    .cfg (cfg_if)
  );

  always #6ns clk = ~clk;

  // Predicted pixels, oldest first.
  pixel_t pixels_due[$];

  // Line engine shadow state.
  coord_t                pen_x, pen_y, goal_x, goal_y;
  int                    run_x, run_y, err_acc;
  bit                    step_x_neg, step_y_neg;
  logic [COLOR_BITS-1:0] ink;
  bit                    line_busy;

  // Shadow of the frame registers.
  logic [DIM_BITS-1:0] frame_w, frame_h;
  bit                  rotated;

  int  mismatches;
  int  items_drawn;
  int  cycle_count;
  bit  tx_gaps_on;
  bit  rx_stalls_on;
  int  rx_hold_cycles;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void reset_shadow();
    pen_x = '0; pen_y = '0; goal_x = '0; goal_y = '0;
    run_x = 0; run_y = 0; err_acc = 0;
    step_x_neg = 1'b0; step_y_neg = 1'b0;
    ink = '0;
    line_busy = 1'b0;
    frame_w = FRAME_WIDTH_RESET;
    frame_h = FRAME_HEIGHT_RESET;
    rotated = 1'b0;
  endfunction

  // Frame-buffer word index; the rotated form wraps in unsigned arithmetic.
  function automatic logic [ADDR_BITS-1:0] word_address(coord_t x, coord_t y);
    logic [63:0] w, h, a;
    w = 64'(frame_w);
    h = 64'(frame_h);
    if (rotated)
      a = (w - 64'(x)) + w * (h - 64'(y));
    else
      a = 64'(x) + w * 64'(y);
    return a[ADDR_BITS-1:0];
  endfunction

  // Apply one accepted command to the shadow engine; queue any pixel it gives.
  function automatic void trace_step(action_t act, coord_t sx, coord_t sy,
                                     coord_t ex, coord_t ey,
                                     logic [COLOR_BITS-1:0] col);
    int     e;
    pixel_t px;
    if (act == ACT_START) begin
      pen_x = sx;
      pen_y = sy;
      goal_x = ex;
      goal_y = ey;
      run_x = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
      run_y = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
      step_x_neg = !(sx < ex);
      step_y_neg = !(sy < ey);
      // Integer division truncates toward zero, as the engine does.
      err_acc = (run_x > run_y ? run_x : -run_y) / 2;
      ink = col;
    end else begin
      // An advance on an idle engine is swallowed.
      if (!line_busy)
        return;
      e = err_acc;
      if (e > -run_x) begin
        err_acc -= run_y;
        pen_x = step_x_neg ? pen_x - COORD_BITS'(1) : pen_x + COORD_BITS'(1);
      end
      if (e < run_y) begin
        err_acc += run_x;
        pen_y = step_y_neg ? pen_y - COORD_BITS'(1) : pen_y + COORD_BITS'(1);
      end
    end
    px.x     = pen_x;
    px.y     = pen_y;
    px.addr  = word_address(pen_x, pen_y);
    px.color = ink;
    px.last  = (pen_x == goal_x) && (pen_y == goal_y);
    line_busy = !px.last;
    pixels_due.push_back(px);
    items_drawn++;
  endfunction

  // --------------------------------------------------------------------------
  // Pixel checker: compare each transfer with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel (%0d,%0d) transferred with none expected",
               pix_if.pixel_x, pix_if.pixel_y);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_x", 32'(want.x), 32'(pix_if.pixel_x));
        check_field("pixel_y", 32'(want.y), 32'(pix_if.pixel_y));
        check_field("pixel_address", 32'(want.addr), 32'(pix_if.pixel_address));
        check_field("pixel_color", 32'(want.color), 32'(pix_if.pixel_color));
        check_field("last", 32'(want.last), 32'(pix_if.last));
      end
    end
  end

  // Bound the run; a hang or a lost pixel ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bresenham_line_pixel_generator_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel receiver: random stall bursts, plus a long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        // Hold off long enough for the queue to fill and back up the input.
        pix_if.ready = 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        pix_if.ready = 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        pix_if.ready = 1'b0;
      end else begin
        pix_if.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command and register drivers
  // --------------------------------------------------------------------------
  // Offer one command, hold it until its transfer, then predict. Valid stays
  // high afterwards so that back-to-back commands stream at full rate.
  task automatic send_cmd(action_t act, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                          logic [COLOR_BITS-1:0] col);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk);
        cmd_if.valid = 1'b0;
      end
    end
    @(negedge clk);
    cmd_if.valid     = 1'b1;
    cmd_if.action    = act;
    cmd_if.start_x   = sx;
    cmd_if.start_y   = sy;
    cmd_if.end_x     = ex;
    cmd_if.end_y     = ey;
    cmd_if.pen_color = col;
    do @(posedge clk); while (!cmd_if.ready);
    trace_step(act, sx, sy, ex, ey, col);
  endtask

  // Advance with junk in the start-only fields.
  task automatic advance();
    send_cmd(ACT_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), COLOR_BITS'($urandom));
  endtask

  // Start a line, then advance until it ends or max_adv steps are spent.
  task automatic draw_line(int x0, int y0, int x1, int y1, logic [COLOR_BITS-1:0] col,
                           int max_adv);
    int n;
    send_cmd(ACT_START, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1), col);
    n = 0;
    while (line_busy && n < max_adv) begin
      advance();
      n++;
    end
  endtask

  // Drop valid, wait for every predicted pixel, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pixels_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; only ever done with the engine drained.
  task automatic program_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_FRAME_WIDTH:  frame_w = val;
      REG_FRAME_HEIGHT: frame_h = val;
      REG_ROTATE_MODE:  rotated = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_frame(int w, int h, int rot);
    program_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
    program_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
    program_reg(REG_ROTATE_MODE, CFG_DATA_BITS'(rot));
  endtask

  // Endpoint within +/-span of c, reflected back when it would leave the grid.
  function automatic int nearby(int c, int span);
    int d, v;
    d = $urandom_range(0, 2 * span) - span;
    v = c + d;
    if (v < 0 || v > 2047)
      v = c - d;
    return v;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 2048;
      2: return 4095;
      default: return $urandom_range(1, 2048);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Advance straight out of reset: no line, so no pixel.
  task automatic test_idle_advance();
    advance();
    wait_drained();
  endtask

  // Corner endpoints, diagonals both ways, colour extremes, a single-point
  // line, a line run to its end, and a start that cuts a line short.
  task automatic test_extreme_lines();
    send_cmd(ACT_START, coord_t'(0), coord_t'(0), coord_t'(2047), coord_t'(2047),
             16'hFFFF);
    repeat (2) advance();
    send_cmd(ACT_START, coord_t'(2047), coord_t'(2047), coord_t'(0), coord_t'(0),
             16'h0000);
    repeat (2) advance();
    // shallow, x falling
    send_cmd(ACT_START, coord_t'(2047), coord_t'(0), coord_t'(0), coord_t'(5), 16'hA5A5);
    repeat (2) advance();
    // steep, y falling
    send_cmd(ACT_START, coord_t'(5), coord_t'(2047), coord_t'(0), coord_t'(0), 16'h5A5A);
    repeat (2) advance();
    // single point: one pixel marked last, then the engine is idle
    send_cmd(ACT_START, coord_t'(2047), coord_t'(0), coord_t'(2047), coord_t'(0),
             16'h8001);
    advance();
    draw_line(10, 10, 13, 11, 16'h1234, 16);
    send_cmd(ACT_START, coord_t'(100), coord_t'(100), coord_t'(200), coord_t'(150),
             16'h00FF);
    advance();
    // vertical line replaces the running one
    draw_line(7, 7, 7, 9, 16'hFF00, 16);
    advance();
    wait_drained();
  endtask

  task automatic corner_lines();
    draw_line(0, 0, 3, 2, COLOR_BITS'($urandom), 16);
    draw_line(2047, 2047, 2044, 2046, COLOR_BITS'($urandom), 16);
    draw_line(2047, 0, 2045, 3, COLOR_BITS'($urandom), 16);
  endtask

  // Address mapping across register extremes in both modes.
  task automatic test_address_mapping();
    apply_frame(1, 1, 0);
    corner_lines();
    apply_frame(2048, 2048, 1);
    corner_lines();
    apply_frame(4095, 4095, 1);
    corner_lines();
    apply_frame(0, 0, 1);
    corner_lines();
    apply_frame(0, 4095, 0);
    corner_lines();
    apply_frame(2048, 1, 1);
    corner_lines();
    program_reg(REG_SPARE, 12'hFFF);
    corner_lines();
    apply_frame(800, 600, 0);
    corner_lines();
    wait_drained();
  endtask

  // Hold the receiver off while commands keep coming, so the input stalls.
  task automatic test_backpressure();
    send_cmd(ACT_START, coord_t'(3), coord_t'(5), coord_t'(1800), coord_t'(900), 16'hC3C3);
    rx_hold_cycles = 250;
    repeat (60) advance();
    wait_drained();
  endtask

  // Stop sending until the engine has handed over every pixel, then resume.
  task automatic test_sender_pause();
    repeat (3) begin
      draw_line(500, 500, nearby(500, 8), nearby(500, 8), COLOR_BITS'($urandom), 32);
      wait_drained();
      advance();
    end
    wait_drained();
  endtask

  // Random phases, each under a fresh frame setting. Mostly complete short
  // lines; the rest are long lines dropped midway, stray advances, lines between
  // arbitrary endpoints, short lines at the grid edges and pauses to drain.
  task automatic test_random_traffic(int target);
    int goal, phase_end, r, x0, y0;
    goal = items_drawn + target;
    while (items_drawn < goal) begin
      apply_frame(pick_dim(), pick_dim(), $urandom_range(0, 1));
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      phase_end = items_drawn + 150;
      while (items_drawn < phase_end && items_drawn < goal) begin
        r  = $urandom_range(0, 99);
        x0 = $urandom_range(0, 2047);
        y0 = $urandom_range(0, 2047);
        if (r < 65) begin
          draw_line(x0, y0, nearby(x0, 12), nearby(y0, 12), COLOR_BITS'($urandom), 64);
        end else if (r < 75) begin
          draw_line(x0, y0, nearby(x0, 200), nearby(y0, 200), COLOR_BITS'($urandom),
                    $urandom_range(0, 30));
        end else if (r < 85) begin
          repeat ($urandom_range(1, 3)) advance();
        end else if (r < 93) begin
          draw_line(x0, y0, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    COLOR_BITS'($urandom), $urandom_range(0, 6));
        end else if (r < 97) begin
          // hug the grid edges
          x0 = $urandom_range(0, 1) ? 2047 : 0;
          y0 = $urandom_range(0, 1) ? 2047 : 0;
          draw_line(x0, y0, nearby(x0, 5), nearby(y0, 5), COLOR_BITS'($urandom), 16);
        end else begin
          wait_drained();
        end
      end
    end
    wait_drained();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream(int target);
    int goal, x0, y0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    goal = items_drawn + target;
    while (items_drawn < goal) begin
      x0 = $urandom_range(0, 2047);
      y0 = $urandom_range(0, 2047);
      draw_line(x0, y0, nearby(x0, 10), nearby(y0, 10), COLOR_BITS'($urandom), 64);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    cmd_if.valid     = 1'b0;
    cmd_if.action    = ACT_START;
    cmd_if.start_x   = '0;
    cmd_if.start_y   = '0;
    cmd_if.end_x     = '0;
    cmd_if.end_y     = '0;
    cmd_if.pen_color = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_FRAME_WIDTH;
    cfg_if.data      = '0;
    mismatches       = 0;
    items_drawn      = 0;
    cycle_count      = 0;
    rx_hold_cycles   = 0;
    tx_gaps_on       = 1'b1;
    rx_stalls_on     = 1'b1;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_advance();
    test_extreme_lines();
    test_address_mapping();
    test_backpressure();
    test_sender_pause();
    test_random_traffic(900);
    test_steady_stream(100);
    wait_drained();

    if (mismatches == 0)
      $display("bresenham_line_pixel_generator_core verification clean");
    else
      $display("bresenham_line_pixel_generator_core verification failed");
    $finish;
  end

endmodule
